// ===== src/secm_pkg.sv =====
// Shared constants, field widths and types of the signal condition event monitor.
// Used by every module of the block; has no dependencies of its own.
package secm_pkg;

	localparam int NUM_EVENTS      = 16;
	localparam int CONDS_PER_EVENT = 8;
	localparam int NUM_SIGNALS     = 256;
	localparam int NUM_RULES       = NUM_EVENTS * CONDS_PER_EVENT;

	localparam int EVI_W   = 4;
	localparam int SLOT_W  = 3;
	localparam int SIGID_W = 8;
	localparam int OP_W    = 3;
	localparam int REL_W   = 2;
	localparam int VAL_W   = 32;
	localparam int SEC_W   = 32;
	localparam int MIC_W   = 20;

	localparam int SIG_AW  = (NUM_SIGNALS > 1) ? $clog2(NUM_SIGNALS) : 1;
	localparam int RULE_AW = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
	localparam int EV_W    = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
	localparam int CS_W    = (CONDS_PER_EVENT > 1) ? $clog2(CONDS_PER_EVENT) : 1;

	localparam logic [OP_W-1:0] OP_EQ = 3'd0;
	localparam logic [OP_W-1:0] OP_GT = 3'd1;
	localparam logic [OP_W-1:0] OP_LT = 3'd2;
	localparam logic [OP_W-1:0] OP_GE = 3'd3;
	localparam logic [OP_W-1:0] OP_LE = 3'd4;
	localparam logic [OP_W-1:0] OP_NE = 3'd5;

	localparam logic [REL_W-1:0] REL_NONE = 2'd0;
	localparam logic [REL_W-1:0] REL_AND  = 2'd1;

	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_UPDATE = 1'b1;

	typedef struct packed {
		logic [SIGID_W-1:0]     sig;
		logic [OP_W-1:0]        op;
		logic [REL_W-1:0]       rel;
		logic signed [VAL_W-1:0] thr;
	} rule_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [SEC_W-1:0]        secs;
		logic [MIC_W-1:0]        micros;
	} sample_t;

	typedef struct packed {
		logic              seen;
		logic              result;
		logic [REL_W-1:0]  cur_rel;
		logic [SEC_W-1:0]  best_s;
		logic [MIC_W-1:0]  best_u;
	} acc_t;

endpackage

// ===== src/secm_sig_store.sv =====
// Signal sample memory with one write port and one registered read port.
// Entries never written since reset read as zero through per-entry valid bits; uses secm_pkg.
module secm_sig_store
	import secm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [SIG_AW-1:0] wr_addr,
	input  sample_t           wr_data,
	input  logic [SIG_AW-1:0] rd_addr,
	input  logic              rd_ok,
	output sample_t           rd_data
);

	sample_t              mem [NUM_SIGNALS];
	logic [NUM_SIGNALS-1:0] written_q;
	sample_t              data_q;
	logic                 hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			hit_q     <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			hit_q <= written_q[rd_addr] && rd_ok;
		end
	end

	assign rd_data = hit_q ? data_q : '0;

endmodule

// ===== src/secm_rule_store.sv =====
// Rule slot memory with one write port and one registered read port.
// Slot valid flags sit in flip-flops cleared by reset; uses secm_pkg.
module secm_rule_store
	import secm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [RULE_AW-1:0] wr_addr,
	input  logic               wr_valid,
	input  rule_t              wr_rule,
	input  logic [RULE_AW-1:0] rd_addr,
	output logic               rd_valid,
	output rule_t              rd_rule
);

	rule_t                mem [NUM_RULES];
	logic [NUM_RULES-1:0] valid_q;
	rule_t                rule_q;
	logic                 vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_rule;
		end
		rule_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= wr_valid;
			end
			vld_q <= valid_q[rd_addr];
		end
	end

	assign rd_valid = vld_q;
	assign rd_rule  = rule_q;

endmodule

// ===== src/secm_eval.sv =====
// Shared condition unit: one threshold compare, the AND/OR join and the latest-time maximum.
// Folds one rule slot into the running state of an event; uses secm_pkg.
module secm_eval
	import secm_pkg::*;
(
	input  acc_t    acc_in,
	input  logic    fresh,
	input  logic    cond_valid,
	input  rule_t   rule,
	input  sample_t smp,
	output acc_t    acc_out
);

	acc_t base;
	logic hit;

	always_comb begin
		base    = fresh ? '0 : acc_in;
		acc_out = base;
		unique case (rule.op)
			OP_EQ:   hit = $signed(smp.value) == $signed(rule.thr);
			OP_GT:   hit = $signed(smp.value) >  $signed(rule.thr);
			OP_LT:   hit = $signed(smp.value) <  $signed(rule.thr);
			OP_GE:   hit = $signed(smp.value) >= $signed(rule.thr);
			OP_LE:   hit = $signed(smp.value) <= $signed(rule.thr);
			OP_NE:   hit = $signed(smp.value) != $signed(rule.thr);
			default: hit = 1'b0;
		endcase
		if (cond_valid) begin
			if (!base.seen) begin
				acc_out.result  = hit;
				acc_out.cur_rel = rule.rel;
				acc_out.seen    = 1'b1;
			end else begin
				if (base.cur_rel == REL_AND) begin
					acc_out.result = base.result && hit;
				end else begin
					acc_out.result = base.result || hit;
				end
				if (rule.rel != REL_NONE) begin
					acc_out.cur_rel = rule.rel;
				end
			end
			if (smp.secs > base.best_s || (smp.secs == base.best_s && smp.micros > base.best_u)) begin
				acc_out.best_s = smp.secs;
				acc_out.best_u = smp.micros;
			end
		end
	end

endmodule

// ===== src/signal_condition_event_monitor_core.sv =====
// Top level of the signal condition event monitor: sequencer, walk pipeline and result output.
// Instantiates secm_rule_store, secm_sig_store and secm_eval; uses secm_pkg.
// An update item walks all rule slots through the shared compare unit, one slot per cycle,
// then scans the events for status changes, stalling while the output is held; s_tready
// stays low, so no new item is taken, until the scan of an update item is done.
// Reset is asynchronous and clears all valid flags and event flags at once, with no clearing pass.
module signal_condition_event_monitor_core
	import secm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// event_index[3:0], cond_slot[6:4], cond_valid[7], signal_id[15:8], compare_op[18:16],
	// relation[20:19], value[52:21], time_seconds[84:53], time_micros[104:85], zeros above.
	input  logic [111:0] s_tdata,
	// mode.
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// event_number[3:0], now_active[4], event_seconds[36:5], event_micros[56:37], zeros above.
	output logic [63:0]  m_tdata,
	output logic         m_tlast
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_WALK  = 4'b0010,
		ST_FLUSH = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t state_q;

	logic [EVI_W-1:0]  in_ev;
	logic [SLOT_W-1:0] in_slot;
	logic              in_cvalid;
	rule_t             in_rule;
	sample_t           in_smp;
	logic              accept;

	assign in_ev        = s_tdata[3:0];
	assign in_slot      = s_tdata[6:4];
	assign in_cvalid    = s_tdata[7];
	assign in_rule.sig  = s_tdata[15:8];
	assign in_rule.op   = s_tdata[18:16];
	assign in_rule.rel  = s_tdata[20:19];
	assign in_rule.thr  = s_tdata[52:21];
	assign in_smp.value = s_tdata[52:21];
	assign in_smp.secs  = s_tdata[84:53];
	assign in_smp.micros = s_tdata[104:85];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	logic               rule_we;
	logic [RULE_AW-1:0] rule_waddr;
	logic               sig_we;

	assign rule_we = accept && (s_tuser == MODE_LOAD) && (32'(in_ev) < 32'(NUM_EVENTS))
		&& (32'(in_slot) < 32'(CONDS_PER_EVENT));
	assign rule_waddr = RULE_AW'(32'(in_ev) * CONDS_PER_EVENT + 32'(in_slot));
	assign sig_we = accept && (s_tuser == MODE_UPDATE)
		&& (32'(in_rule.sig) < 32'(NUM_SIGNALS));

	logic [RULE_AW-1:0] k_q;
	logic [CS_W-1:0]    slot_q;
	logic [EV_W-1:0]    ev_q;
	logic [EV_W-1:0]    e_q;

	logic               rvalid_s1;
	rule_t              rule_s1;
	logic               iss_s1, first_s1, end_s1;
	logic [EV_W-1:0]    ev_s1;
	logic               iss_s2, first_s2, end_s2, rvalid_s2;
	logic [EV_W-1:0]    ev_s2;
	rule_t              rule_s2;
	sample_t            smp_s2;

	secm_rule_store u_rules (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (rule_we),
		.wr_addr  (rule_waddr),
		.wr_valid (in_cvalid),
		.wr_rule  (in_rule),
		.rd_addr  (k_q),
		.rd_valid (rvalid_s1),
		.rd_rule  (rule_s1)
	);

	secm_sig_store u_sigs (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (sig_we),
		.wr_addr (SIG_AW'(in_rule.sig)),
		.wr_data (in_smp),
		.rd_addr (SIG_AW'(rule_s1.sig)),
		.rd_ok   (32'(rule_s1.sig) < 32'(NUM_SIGNALS)),
		.rd_data (smp_s2)
	);

	acc_t acc_q;
	acc_t acc_next;

	secm_eval u_eval (
		.acc_in     (acc_q),
		.fresh      (first_s2),
		.cond_valid (rvalid_s2),
		.rule       (rule_s2),
		.smp        (smp_s2),
		.acc_out    (acc_next)
	);

	logic [NUM_EVENTS-1:0]      active_q;
	logic [NUM_EVENTS-1:0]      changed_q;
	logic [SEC_W+MIC_W-1:0]     tbuf_q [NUM_EVENTS];
	logic                       out_free;
	logic                       above;

	logic [EVI_W-1:0] out_ev_q;
	logic             out_act_q;
	logic [SEC_W-1:0] out_sec_q;
	logic [MIC_W-1:0] out_mic_q;
	logic             out_last_q;
	logic             m_tvalid_q;

	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		above = 1'b0;
		for (int i = 0; i < NUM_EVENTS; i++) begin
			if (changed_q[i] && (i > int'(e_q))) begin
				above = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rule_s2  <= rule_s1;
		ev_s1    <= ev_q;
		ev_s2    <= ev_s1;
		first_s1 <= (slot_q == '0);
		first_s2 <= first_s1;
		end_s1   <= (slot_q == CS_W'(CONDS_PER_EVENT - 1));
		end_s2   <= end_s1;
		if (iss_s2) begin
			acc_q <= acc_next;
			if (end_s2) begin
				tbuf_q[ev_s2] <= {acc_next.best_s, acc_next.best_u};
			end
		end
		if (state_q == ST_EMIT && out_free && changed_q[e_q]) begin
			out_ev_q   <= EVI_W'(e_q);
			out_act_q  <= active_q[e_q];
			out_sec_q  <= tbuf_q[e_q][SEC_W+MIC_W-1:MIC_W];
			out_mic_q  <= tbuf_q[e_q][MIC_W-1:0];
			out_last_q <= !above;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			k_q        <= '0;
			slot_q     <= '0;
			ev_q       <= '0;
			e_q        <= '0;
			iss_s1     <= 1'b0;
			iss_s2     <= 1'b0;
			rvalid_s2  <= 1'b0;
			active_q   <= '0;
			changed_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			iss_s1    <= (state_q == ST_WALK);
			iss_s2    <= iss_s1;
			rvalid_s2 <= rvalid_s1;
			if (iss_s2 && end_s2) begin
				changed_q[ev_s2] <= acc_next.result != active_q[ev_s2];
				active_q[ev_s2]  <= acc_next.result;
			end
			if (state_q == ST_EMIT && out_free && changed_q[e_q]) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && s_tuser == MODE_UPDATE) begin
						k_q     <= '0;
						slot_q  <= '0;
						ev_q    <= '0;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					k_q <= k_q + 1'b1;
					if (slot_q == CS_W'(CONDS_PER_EVENT - 1)) begin
						slot_q <= '0;
						ev_q   <= ev_q + 1'b1;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
					if (k_q == RULE_AW'(NUM_RULES - 1)) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (!iss_s1 && !iss_s2) begin
						e_q     <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (changed_q[e_q]) begin
							changed_q[e_q]   <= 1'b0;
						end
						e_q <= e_q + 1'b1;
						if (e_q == EV_W'(NUM_EVENTS - 1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {7'd0, out_mic_q, out_sec_q, out_act_q, out_ev_q};

endmodule

// ===== dv/signal_condition_event_monitor_core_tb.sv =====
// Testbench for signal_condition_event_monitor_core: drives rule loads and signal updates,
// predicts every event status change in a model of its own and checks each result item.
// Depends on secm_pkg and the core RTL only.
module signal_condition_event_monitor_core_tb
	import secm_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [REL_W-1:0] REL_OR    = 2'd2;
	localparam logic [REL_W-1:0] REL_CODE3 = 2'd3;
	localparam int RX_HOLD_CYCLES = 600;
	localparam int SETTLE_CYCLES  = 200;

	typedef struct {
		logic                    mode;
		logic [EVI_W-1:0]        ev;
		logic [SLOT_W-1:0]       slot;
		logic                    valid;
		logic [SIGID_W-1:0]      sig;
		logic [OP_W-1:0]         op;
		logic [REL_W-1:0]        rel;
		logic signed [VAL_W-1:0] value;
		logic [SEC_W-1:0]        secs;
		logic [MIC_W-1:0]        micros;
	} monitor_item_t;

	typedef struct {
		logic [EVI_W-1:0] ev_num;
		logic             active;
		logic [SEC_W-1:0] secs;
		logic [MIC_W-1:0] micros;
		logic             is_last;
	} status_change_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [111:0] s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [63:0]  m_tdata;
	logic         m_tlast;

	logic signed [VAL_W-1:0] sig_value [NUM_SIGNALS];
	logic [SEC_W-1:0]        sig_secs [NUM_SIGNALS];
	logic [MIC_W-1:0]        sig_micros [NUM_SIGNALS];
	rule_t                   rule_body [NUM_RULES];
	logic                    rule_present [NUM_RULES];
	logic                    event_on [NUM_EVENTS];
	status_change_t          expected_changes [$];

	logic [SEC_W-1:0] stamp_s = 32'd1000;
	bit quiet_tx = 1'b0;
	bit quiet_rx = 1'b0;
	bit rx_hold_req = 1'b0;
	int errors = 0;

	signal_condition_event_monitor_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	initial begin
		#(20_000_000);
		$display("signal_condition_event_monitor_core verification failed");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic logic condition_holds(input logic signed [VAL_W-1:0] a,
			input logic signed [VAL_W-1:0] b, input logic [OP_W-1:0] op);
		case (op)
			OP_EQ: return a == b;
			OP_GT: return a > b;
			OP_LT: return a < b;
			OP_GE: return a >= b;
			OP_LE: return a <= b;
			OP_NE: return a != b;
			default: return 1'b0;
		endcase
	endfunction

	function automatic void store_rule(input monitor_item_t it);
		int idx;
		if (it.ev < NUM_EVENTS && it.slot < CONDS_PER_EVENT) begin
			idx = it.ev * CONDS_PER_EVENT + it.slot;
			rule_present[idx] = it.valid;
			rule_body[idx].sig = it.sig;
			rule_body[idx].op = it.op;
			rule_body[idx].rel = it.rel;
			rule_body[idx].thr = it.value;
		end
	endfunction

	function automatic void evaluate_update(input monitor_item_t it);
		int idx;
		int n;
		logic seen;
		logic res;
		logic hit;
		logic [REL_W-1:0] cur_rel;
		logic [SEC_W-1:0] best_s;
		logic [SEC_W-1:0] ts;
		logic [MIC_W-1:0] best_u;
		logic [MIC_W-1:0] tu;
		logic signed [VAL_W-1:0] act;
		logic signed [VAL_W-1:0] thr;
		status_change_t chg;
		n = 0;
		if (it.sig < NUM_SIGNALS) begin
			sig_value[it.sig] = it.value;
			sig_secs[it.sig] = it.secs;
			sig_micros[it.sig] = it.micros;
		end
		for (int e = 0; e < NUM_EVENTS; e++) begin
			seen = 1'b0;
			res = 1'b0;
			cur_rel = REL_NONE;
			best_s = '0;
			best_u = '0;
			for (int c = 0; c < CONDS_PER_EVENT; c++) begin
				idx = e * CONDS_PER_EVENT + c;
				if (rule_present[idx]) begin
					act = '0;
					ts = '0;
					tu = '0;
					if (rule_body[idx].sig < NUM_SIGNALS) begin
						act = sig_value[rule_body[idx].sig];
						ts = sig_secs[rule_body[idx].sig];
						tu = sig_micros[rule_body[idx].sig];
					end
					thr = rule_body[idx].thr;
					hit = condition_holds(act, thr, rule_body[idx].op);
					if (!seen) begin
						res = hit;
						cur_rel = rule_body[idx].rel;
						seen = 1'b1;
					end else begin
						res = (cur_rel == REL_AND) ? (res && hit) : (res || hit);
						if (rule_body[idx].rel != REL_NONE)
							cur_rel = rule_body[idx].rel;
					end
					if (ts > best_s || (ts == best_s && tu > best_u)) begin
						best_s = ts;
						best_u = tu;
					end
				end
			end
			if (res != event_on[e]) begin
				event_on[e] = res;
				chg.ev_num = EVI_W'(e);
				chg.active = res;
				chg.secs = best_s;
				chg.micros = best_u;
				chg.is_last = 1'b0;
				expected_changes.push_back(chg);
				n++;
			end
		end
		if (n > 0)
			expected_changes[expected_changes.size() - 1].is_last = 1'b1;
	endfunction

	function automatic logic signed [VAL_W-1:0] rand_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5, 6: return (int'($urandom_range(0, 6)) - 3) * 65536;
			7: return int'($urandom_range(0, 6)) - 3;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [SIGID_W-1:0] rand_signal();
		if ($urandom_range(0, 4) != 0)
			return SIGID_W'($urandom_range(0, 7));
		return SIGID_W'($urandom);
	endfunction

	function automatic monitor_item_t random_item();
		monitor_item_t it;
		it.mode = ($urandom_range(0, 9) < 3) ? MODE_LOAD : MODE_UPDATE;
		it.ev = EVI_W'($urandom);
		it.slot = SLOT_W'($urandom);
		it.valid = ($urandom_range(0, 7) != 0);
		it.sig = rand_signal();
		it.op = OP_W'($urandom);
		it.rel = REL_W'($urandom);
		it.value = rand_value();
		case ($urandom_range(0, 9))
			0: stamp_s = $urandom;
			1, 2: ;
			default: stamp_s = stamp_s + $urandom_range(1, 5);
		endcase
		it.secs = stamp_s;
		it.micros = ($urandom_range(0, 7) == 0) ? MIC_W'($urandom)
			: MIC_W'($urandom_range(0, 999999));
		return it;
	endfunction

	function automatic monitor_item_t make_load(input int ev, input int slot, input logic valid,
			input int sig, input logic [OP_W-1:0] op, input logic [REL_W-1:0] rel,
			input logic signed [VAL_W-1:0] thr);
		monitor_item_t it;
		it = random_item();
		it.mode = MODE_LOAD;
		it.ev = EVI_W'(ev);
		it.slot = SLOT_W'(slot);
		it.valid = valid;
		it.sig = SIGID_W'(sig);
		it.op = op;
		it.rel = rel;
		it.value = thr;
		return it;
	endfunction

	function automatic monitor_item_t make_update(input int sig,
			input logic signed [VAL_W-1:0] value, input logic [SEC_W-1:0] secs,
			input logic [MIC_W-1:0] micros);
		monitor_item_t it;
		it = random_item();
		it.mode = MODE_UPDATE;
		it.sig = SIGID_W'(sig);
		it.value = value;
		it.secs = secs;
		it.micros = micros;
		return it;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_item(input monitor_item_t it);
		int gap;
		gap = quiet_tx ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.mode;
		s_tdata <= {7'd0, it.micros, it.secs, it.value, it.rel, it.op, it.sig, it.valid,
			it.slot, it.ev};
		do @(posedge clk); while (!s_tready);
		if (it.mode == MODE_LOAD)
			store_rule(it);
		else
			evaluate_update(it);
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_changes.size() != 0)
			@(posedge clk);
	endtask

	initial begin : result_receiver
		int hold;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
			end else if (!quiet_rx && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				hold = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
					: $urandom_range(1, 3);
				repeat (hold) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : result_checker
		status_change_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_changes.size() == 0) begin
				report_mismatch("unexpected result item", m_tdata[31:0], 32'd0);
			end else begin
				want = expected_changes.pop_front();
				if (m_tdata[3:0] !== want.ev_num)
					report_mismatch("event_number", 32'(m_tdata[3:0]), 32'(want.ev_num));
				if (m_tdata[4] !== want.active)
					report_mismatch("now_active", 32'(m_tdata[4]), 32'(want.active));
				if (m_tdata[36:5] !== want.secs)
					report_mismatch("event_seconds", m_tdata[36:5], want.secs);
				if (m_tdata[56:37] !== want.micros)
					report_mismatch("event_micros", 32'(m_tdata[56:37]), 32'(want.micros));
				if (m_tlast !== want.is_last)
					report_mismatch("last", 32'(m_tlast), 32'(want.is_last));
			end
		end
	end

	task automatic test_compare_ops();
		for (int op = 0; op < 8; op++)
			send_item(make_load(op, 0, 1'b1, 1, OP_W'(op), REL_NONE, 32'sd0));
		send_item(make_update(1, 32'sd0, 32'd100, 20'd5));
		send_item(make_update(1, 32'sh7FFFFFFF, 32'hFFFFFFFF, 20'hFFFFF));
		send_item(make_update(1, 32'sh80000000, 32'd1, 20'd999999));
		wait_for_results();
	endtask

	task automatic test_relations();
		send_item(make_load(8, 0, 1'b1, 2, OP_GT, REL_AND, 32'sd0));
		send_item(make_load(8, 3, 1'b1, 3, OP_EQ, REL_CODE3, 32'sd5 * 65536));
		send_item(make_load(8, 7, 1'b1, 4, OP_GT, REL_NONE, 32'sd0));
		send_item(make_load(9, 1, 1'b1, 5, OP_EQ, REL_OR, -32'sd65536));
		send_item(make_load(9, 2, 1'b1, 6, OP_NE, REL_NONE, 32'sd0));
		send_item(make_load(9, 4, 1'b0, 7, OP_EQ, REL_AND, 32'sd0));
		send_item(make_load(9, 6, 1'b1, 255, OP_LT, REL_AND, 32'sd0));
		send_item(make_update(2, 32'sd65536, 32'd200, 20'd10));
		send_item(make_update(3, 32'sd5 * 65536, 32'd200, 20'd9));
		send_item(make_update(5, -32'sd65536, 32'd300, 20'hFFFFF));
		send_item(make_load(8, 0, 1'b0, 2, OP_GT, REL_AND, 32'sd0));
		send_item(make_load(0, 0, 1'b0, 1, OP_EQ, REL_NONE, 32'sd0));
		send_item(make_update(255, -32'sd7, 32'hFFFFFFFF, 20'd0));
		wait_for_results();
	endtask

	task automatic test_back_to_back();
		quiet_tx = 1'b1;
		quiet_rx = 1'b1;
		repeat (40) send_item(random_item());
		wait_for_results();
		quiet_tx = 1'b0;
		quiet_rx = 1'b0;
	endtask

	task automatic test_random_mix();
		repeat (200) send_item(random_item());
		wait_for_results();
	endtask

	task automatic test_output_stall();
		int i;
		rx_hold_req = 1'b1;
		quiet_tx = 1'b1;
		for (i = 0; i < 20; i++)
			send_item(make_update(i % 8, (i % 2 == 0) ? 32'sh7FFFFFFF : 32'sh80000000,
				32'd5000 + i, MIC_W'(i)));
		quiet_tx = 1'b0;
		wait_for_results();
	endtask

	initial begin
		sig_value = '{default: '0};
		sig_secs = '{default: '0};
		sig_micros = '{default: '0};
		rule_body = '{default: '0};
		rule_present = '{default: 1'b0};
		event_on = '{default: 1'b0};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_compare_ops();
		test_relations();
		test_back_to_back();
		test_random_mix();
		test_output_stall();
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_changes.size() != 0)
			report_mismatch("result items missing", 32'd0, expected_changes.size());
		if (errors == 0)
			$display("signal_condition_event_monitor_core verification clean");
		else
			$display("signal_condition_event_monitor_core verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/secm_pkg.sv
src/secm_sig_store.sv
src/secm_rule_store.sv
src/secm_eval.sv
src/signal_condition_event_monitor_core.sv
dv/signal_condition_event_monitor_core_tb.sv
